// File: sv/lcs_pkg.sv
// lane cubic sampler: shared constants, state, slot and tag types
// no dependencies; imported by lane_cubic_sampler_unit
package lcs_pkg;

  localparam int MAX_STEPS = 64;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  // piece kinds carried by the op field
  localparam logic [1:0] OP_REAR   = 2'd0;
  localparam logic [1:0] OP_FIRST  = 2'd1;
  localparam logic [1:0] OP_SECOND = 2'd2;

  localparam logic signed [16:0] GRID_CM     = 17'sd250;
  localparam logic signed [16:0] TOP_GRID_CM = 17'sd32750;
  localparam logic signed [16:0] SAT_FROM_CM = 17'sd32517;
  localparam logic signed [15:0] X_MAX_CM    = 16'sd32767;
  localparam logic signed [16:0] BACK_CM     = 17'sd500;

  // floor(a / 250) = (a * 67109) >> 24 for every a up to 2^16
  localparam logic [31:0] RECIP_250   = 32'd67109;
  localparam int          RECIP_SHIFT = 24;

  // y = (poly + 2^26) >>> 27
  localparam logic signed [63:0] ROUND_HALF = 64'sd67108864;
  localparam int                 Y_SHIFT    = 27;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN_MUL,
    ST_ALIGN_FIX,
    ST_EVAL,
    ST_DIFF,
    ST_STEP
  } state_t;

  // multiplier issue slots of one polynomial evaluation
  typedef enum logic [2:0] {
    SL_SQUARE,
    SL_LINEAR,
    SL_CUBE,
    SL_QUAD,
    SL_CUBIC,
    SL_DRAIN
  } slot_t;

  // where the registered product goes in the following cycle
  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_K2,
    TAG_K3,
    TAG_ACC
  } mul_tag_t;

endpackage

// File: sv/lane_cubic_sampler_unit.sv
// lane cubic sampler top level: grid alignment, cubic setup on one shared multiplier,
// forward-difference stepping and the result register; depends on lcs_pkg
//
// channel  ports                                   direction  moves
// in       in_valid/in_ready + in_* fields         input      one cubic piece per request
// out      out_valid/out_ready + out_* fields      output     one sample point per request
//
// a rear piece is aligned through the shared multiplier in ST_ALIGN_MUL and ST_ALIGN_FIX;
// a piece that is sampled then runs four cubic evaluations of 6 multiplier slots, then 3
// difference passes, then one grid step per cycle unless a step stalls, at most MAX_STEPS
// steps, and a closing step that ends the piece.
// an unused forward piece or an unknown op goes back to accepting the cycle after it
// arrives; a rear piece starting at or above zero does so after ST_ALIGN_MUL and ST_ALIGN_FIX.
// reset clears the carried position and back shift; in_ready is high only while idle.
// one point is held back to learn its last flag; a step stalls when it must push that
// point out and the output register is still full, and the closing cycle waits the same way.
module lane_cubic_sampler_unit
  import lcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic                in_piece_valid,
  input  logic signed [31:0]  in_coef0,
  input  logic signed [31:0]  in_coef1,
  input  logic signed [31:0]  in_coef2,
  input  logic signed [31:0]  in_coef3,
  input  logic signed [15:0]  in_start_cm,
  input  logic signed [15:0]  in_end_cm,

  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_point_x_cm,
  output logic signed [39:0]  out_point_y,
  output logic [1:0]          out_piece_kind,
  output logic                out_last,
  output logic                out_overflow
);

  state_t state_r, state_nxt;
  slot_t  slot_r;
  logic [1:0] eval_r;
  logic [1:0] pass_r;

  // captured piece
  logic [1:0]         kind_r;
  logic signed [31:0] c1_r, c2_r, c3_r;
  logic signed [15:0] start_r;
  logic signed [16:0] lim_r, skip_r;
  logic               incl_r, skip_on_r;

  // carried position
  logic signed [15:0] x_r;
  logic signed [8:0]  k_r;
  logic               back_r;

  // multiplier and its operands
  logic [15:0]        k2_r;
  logic signed [22:0] k3_r;
  logic signed [63:0] prod_r;
  mul_tag_t           prod_tag_r, issue_tag;
  logic [1:0]         prod_idx_r;
  logic signed [31:0] mul_a, mul_b;

  // P, D1, D2, D3 once the difference passes are done
  logic signed [63:0] acc_r [4];

  logic [STEP_W-1:0]  steps_r;

  logic               pend_v_r;
  logic signed [15:0] pend_x_r;
  logic signed [39:0] pend_y_r;

  logic               out_valid_r;
  logic signed [15:0] out_x_r;
  logic signed [39:0] out_y_r;
  logic [1:0]         out_kind_r;
  logic               out_last_r, out_ovf_r;

  // accept-side decode
  logic               in_fire;
  logic               coef_nz, fwd_used, back_new;
  logic signed [16:0] start17_in, end17_in;
  logic signed [63:0] c0_scaled;

  assign in_fire    = in_valid && in_ready;
  assign coef_nz    = |{in_coef0, in_coef1, in_coef2, in_coef3};
  assign fwd_used   = ((in_op == OP_FIRST) || (in_op == OP_SECOND)) && in_piece_valid &&
                      (in_end_cm > in_start_cm) && coef_nz;
  assign start17_in = {in_start_cm[15], in_start_cm};
  assign end17_in   = {in_end_cm[15], in_end_cm};
  assign back_new   = in_start_cm[15] && (end17_in < -BACK_CM);
  assign c0_scaled  = $signed({{5{in_coef0[31]}}, in_coef0, 27'd0}) + ROUND_HALF;

  // alignment
  logic signed [16:0] start17_r, abs_start;
  logic [7:0]         q_align;
  logic signed [8:0]  k_align;
  logic signed [16:0] k_align17, x_align17;

  assign start17_r = {start_r[15], start_r};
  assign abs_start = start_r[15] ? -start17_r : start17_r;
  assign q_align   = prod_r[RECIP_SHIFT +: 8];
  assign k_align   = start_r[15] ? -$signed({1'b0, q_align}) : $signed({1'b0, q_align});
  assign k_align17 = {{8{k_align[8]}}, k_align};
  assign x_align17 = (k_align17 <<< 8) - (k_align17 <<< 2) - (k_align17 <<< 1);

  // operand shapes: 1310720*k, 12800*k^2, 125*k^3
  logic signed [8:0]  k_e;
  logic signed [31:0] k_e32, k2_32, k3_32, b_lin, b_quad, b_cub;

  assign k_e    = k_r + $signed({7'd0, eval_r});
  assign k_e32  = {{23{k_e[8]}}, k_e};
  assign k2_32  = $signed({16'd0, k2_r});
  assign k3_32  = {{9{k3_r[22]}}, k3_r};
  assign b_lin  = (k_e32 <<< 20) + (k_e32 <<< 18);
  assign b_quad = (k2_32 <<< 13) + (k2_32 <<< 12) + (k2_32 <<< 9);
  assign b_cub  = (k3_32 <<< 7) - (k3_32 <<< 1) - k3_32;

  // stepping
  logic signed [16:0] xs;
  logic               cont, room, skip_now, emit, out_free;
  logic               adv, fin, flush, push_pend;
  logic signed [39:0] y_now;

  assign xs       = {x_r[15], x_r};
  assign cont     = (xs <= TOP_GRID_CM) && (incl_r ? (xs <= lim_r) : (xs < lim_r));
  assign room     = (steps_r != STEP_W'(MAX_STEPS));
  assign skip_now = skip_on_r && (xs < skip_r);
  assign emit     = cont && room && !skip_now;
  assign out_free = !out_valid_r || out_ready;
  assign y_now    = {{3{acc_r[0][63]}}, acc_r[0][63:Y_SHIFT]};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_REAR) begin
            state_nxt = ST_ALIGN_MUL;
          end else if (fwd_used) begin
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_ALIGN_MUL: state_nxt = ST_ALIGN_FIX;
      ST_ALIGN_FIX: state_nxt = start_r[15] ? ST_EVAL : ST_IDLE;
      ST_EVAL: begin
        if ((slot_r == SL_DRAIN) && (eval_r == 2'd3)) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (pass_r == 2'd2) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!(cont && room) && (!pend_v_r || out_free)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, multiplier issue, step strobes
  always_comb begin
    in_ready  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    issue_tag = TAG_NONE;
    adv       = 1'b0;
    fin       = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_ALIGN_MUL: begin
        mul_a = $signed({15'd0, abs_start});
        mul_b = $signed(RECIP_250);
      end
      ST_EVAL: begin
        case (slot_r)
          SL_SQUARE: begin
            mul_a     = k_e32;
            mul_b     = k_e32;
            issue_tag = TAG_K2;
          end
          SL_LINEAR: begin
            mul_a     = c1_r;
            mul_b     = b_lin;
            issue_tag = TAG_ACC;
          end
          SL_CUBE: begin
            mul_a     = k2_32;
            mul_b     = k_e32;
            issue_tag = TAG_K3;
          end
          SL_QUAD: begin
            mul_a     = c2_r;
            mul_b     = b_quad;
            issue_tag = TAG_ACC;
          end
          SL_CUBIC: begin
            mul_a     = c3_r;
            mul_b     = b_cub;
            issue_tag = TAG_ACC;
          end
          default: issue_tag = TAG_NONE;
        endcase
      end
      ST_STEP: begin
        adv = cont && room && (!emit || !pend_v_r || out_free);
        fin = !(cont && room);
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign flush     = fin && pend_v_r && out_free;
  assign push_pend = adv && emit && pend_v_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= SL_SQUARE;
      eval_r      <= '0;
      pass_r      <= '0;
      prod_tag_r  <= TAG_NONE;
      steps_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      x_r         <= '0;
      k_r         <= '0;
      back_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prod_tag_r <= issue_tag;

      if (in_fire) begin
        slot_r  <= SL_SQUARE;
        eval_r  <= '0;
        pass_r  <= '0;
        steps_r <= '0;
        if (in_op == OP_REAR) begin
          back_r <= back_new;
        end
      end

      if (state_r == ST_ALIGN_FIX) begin
        k_r <= k_align;
        x_r <= x_align17[15:0];
      end

      if (state_r == ST_EVAL) begin
        if (slot_r == SL_DRAIN) begin
          slot_r <= SL_SQUARE;
          eval_r <= eval_r + 2'd1;
        end else begin
          slot_r <= slot_t'(slot_r + 3'd1);
        end
      end

      if (state_r == ST_DIFF) begin
        pass_r <= pass_r + 2'd1;
      end

      if (adv) begin
        x_r     <= (xs > SAT_FROM_CM) ? X_MAX_CM : 16'(xs + GRID_CM);
        k_r     <= k_r + 9'sd1;
        steps_r <= steps_r + STEP_W'(1);
        if (emit) begin
          pend_v_r <= 1'b1;
        end
      end else if (flush) begin
        pend_v_r <= 1'b0;
      end

      if (push_pend || flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r     <= 64'(mul_a) * 64'(mul_b);
    prod_idx_r <= eval_r;

    if (in_fire) begin
      kind_r  <= in_op;
      c1_r    <= in_coef1;
      c2_r    <= in_coef2;
      c3_r    <= in_coef3;
      start_r <= in_start_cm;
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= c0_scaled;
      end
      if (in_op == OP_REAR) begin
        lim_r     <= end17_in - (back_new ? BACK_CM : 17'sd0);
        incl_r    <= 1'b0;
        skip_on_r <= 1'b0;
        skip_r    <= start17_in;
      end else begin
        lim_r     <= end17_in;
        incl_r    <= 1'b1;
        skip_on_r <= 1'b1;
        // the first forward piece reuses the rear piece's back shift
        skip_r    <= start17_in - (((in_op == OP_FIRST) && back_r) ? BACK_CM : 17'sd0);
      end
    end

    case (prod_tag_r)
      TAG_K2:  k2_r <= prod_r[15:0];
      TAG_K3:  k3_r <= prod_r[22:0];
      TAG_ACC: acc_r[prod_idx_r] <= acc_r[prod_idx_r] + prod_r;
      default: ;
    endcase

    // turn P(k), P(k+1), P(k+2), P(k+3) into P, D1, D2, D3
    if (state_r == ST_DIFF) begin
      for (int i = 1; i < 4; i++) begin
        if (2'(i) > pass_r) begin
          acc_r[i] <= acc_r[i] - acc_r[i-1];
        end
      end
    end

    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= acc_r[i] + acc_r[i+1];
      end
      if (emit) begin
        pend_x_r <= x_r;
        pend_y_r <= y_now;
      end
    end

    if (push_pend || flush) begin
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_kind_r <= kind_r;
      out_last_r <= flush;
      out_ovf_r  <= flush && cont;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x_cm = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_piece_kind = out_kind_r;
  assign out_last       = out_last_r;
  assign out_overflow   = out_ovf_r;

endmodule
